>>> rtl/pcsa_pkg.sv
package pcsa_pkg;

    // Field widths
    localparam int unsigned ANGLE_W = 32;
    localparam int unsigned SINE_W  = 16;

    // Defaults for the top-level parameters
    localparam int unsigned ANGLE_FRAC_BITS_DEF  = 16;
    localparam int unsigned RESULT_FRAC_BITS_DEF = 14;

    // Queue depth between the parts and on the result side
    localparam int unsigned QUEUE_DEPTH = 4;

    // Internal angle format: Q.32
    localparam int unsigned INNER_FRAC = 32;

    // Reciprocal of 2*pi, unsigned Q.32
    localparam int unsigned INV_W = 30;
    localparam logic [INV_W-1:0] INV_TWO_PI_Q32 = 30'h28BE60DC;

    // 2*pi in Q.32 as a multiplier operand
    localparam int unsigned TWO_PI_W = 36;
    localparam logic signed [TWO_PI_W-1:0] TWO_PI_Q32 = 36'sh6487ED510;

    // Remainder width and the quadrant bounds at that width
    localparam int unsigned R_W = 37;
    localparam logic signed [R_W-1:0] HALF_PI_R       = 37'sh01921FB544;
    localparam logic signed [R_W-1:0] PI_R            = 37'sh03243F6A88;
    localparam logic signed [R_W-1:0] THREE_HALF_PI_R = 37'sh04B65F1FCC;
    localparam logic signed [R_W-1:0] TWO_PI_R        = 37'sh06487ED510;

    // Quadrant offset t (Q.32) and the polynomial operand widths
    localparam int unsigned T_W  = 33;
    localparam int unsigned TQ_W = T_W - 2;
    localparam int unsigned T2_W = 32;
    localparam int unsigned T3_W = 33;

    // Polynomial coefficients, Q.30
    localparam logic signed [30:0] A2_Q30 = -31'sd621948235;
    localparam logic signed [27:0] A3_Q30 = 28'sd118905972;

    // Accumulator, Q.60
    localparam int unsigned ACC_W    = 64;
    localparam int unsigned ACC_FRAC = 60;
    localparam logic signed [ACC_W-1:0] ONE_Q60 = 64'sh1000_0000_0000_0000;

    // Item passed from the front part to the back part
    typedef struct packed {
        logic           neg;
        logic [T_W-1:0] t;
    } pcsa_mid_t;

endpackage

>>> rtl/pcsa_fifo.sv
module pcsa_fifo #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = pcsa_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> rtl/pcsa_front.sv
module pcsa_front #(
    parameter int unsigned ANGLE_FRAC_BITS = pcsa_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pcsa_pkg::ANGLE_W-1:0]   angle,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output pcsa_pkg::pcsa_mid_t                   out_item
);

    import pcsa_pkg::*;

    localparam int unsigned NSTG = 5;
    localparam int unsigned QS   = ANGLE_FRAC_BITS + INNER_FRAC;
    localparam int unsigned P_W  = ANGLE_W + INV_W + 1;
    localparam int unsigned Q_W  = P_W - QS;
    localparam int unsigned XW_W = ANGLE_W + INNER_FRAC - ANGLE_FRAC_BITS;
    localparam int unsigned PR_W = Q_W + TWO_PI_W;
    localparam logic [P_W-1:0] Q_RND = (P_W'(1) << QS) - P_W'(1);

    logic                       adv;
    logic [NSTG-1:0]            vld_reg;
    logic [NSTG-1:0]            vld_next;

    logic signed [P_W-1:0]      p_reg;
    logic signed [P_W-1:0]      p_next;
    logic signed [ANGLE_W-1:0]  a0_reg;
    logic signed [Q_W-1:0]      q_reg;
    logic signed [Q_W-1:0]      q_next;
    logic signed [ANGLE_W-1:0]  a1_reg;
    logic signed [PR_W-1:0]     prod_reg;
    logic signed [PR_W-1:0]     prod_next;
    logic signed [ANGLE_W-1:0]  a2_reg;
    logic signed [R_W-1:0]      r_reg;
    logic signed [R_W-1:0]      r_next;
    pcsa_mid_t                  item_reg;
    pcsa_mid_t                  item_next;

    logic [P_W-1:0]             p_adj;
    logic [XW_W-1:0]            xw;
    logic signed [PR_W-1:0]     diff;
    logic signed [R_W-1:0]      r_raw;
    logic signed [R_W-1:0]      dq;

    assign adv       = !vld_reg[NSTG-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[NSTG-1];
    assign out_item  = item_reg;

    always_comb
    begin
        vld_next = adv ? {vld_reg[NSTG-2:0], in_valid} : vld_reg;

        // quotient estimate by reciprocal multiply
        p_next = angle * $signed({1'b0, INV_TWO_PI_Q32});

        // truncate toward zero: bias negative products before the shift
        p_adj  = p_reg + (p_reg[P_W-1] ? Q_RND : '0);
        q_next = $signed(p_adj[P_W-1:QS]);

        prod_next = q_reg * TWO_PI_Q32;

        // remainder, folded into range once
        xw     = {a2_reg, {(INNER_FRAC - ANGLE_FRAC_BITS){1'b0}}};
        diff   = $signed({{(PR_W - XW_W){xw[XW_W-1]}}, xw}) - prod_reg;
        r_raw  = diff[R_W-1:0];
        r_next = r_raw[R_W-1] ? r_raw + TWO_PI_R : r_raw;

        // quadrant and offset from the nearest peak
        if (r_reg < HALF_PI_R)
        begin
            dq            = HALF_PI_R - r_reg;
            item_next.neg = 1'b0;
        end
        else if (r_reg < PI_R)
        begin
            dq            = r_reg - HALF_PI_R;
            item_next.neg = 1'b0;
        end
        else if (r_reg < THREE_HALF_PI_R)
        begin
            dq            = THREE_HALF_PI_R - r_reg;
            item_next.neg = 1'b1;
        end
        else
        begin
            dq            = r_reg - THREE_HALF_PI_R;
            item_next.neg = 1'b1;
        end
        item_next.t = dq[T_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg    <= p_next;
            a0_reg   <= angle;
            q_reg    <= q_next;
            a1_reg   <= a0_reg;
            prod_reg <= prod_next;
            a2_reg   <= a1_reg;
            r_reg    <= r_next;
            item_reg <= item_next;
        end
    end

endmodule

>>> rtl/pcsa_back.sv
module pcsa_back #(
    parameter int unsigned RESULT_FRAC_BITS = pcsa_pkg::RESULT_FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  pcsa_pkg::pcsa_mid_t           in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pcsa_pkg::SINE_W-1:0]   sine_value
);

    import pcsa_pkg::*;

    localparam int unsigned NSTG = 5;
    localparam int unsigned SH   = ACC_FRAC - RESULT_FRAC_BITS;
    localparam int unsigned VW   = RESULT_FRAC_BITS + 3;
    localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) << (SH - 1);
    localparam logic signed [VW-1:0] V_ONE =
        {{(VW - RESULT_FRAC_BITS - 1){1'b0}}, 1'b1, {RESULT_FRAC_BITS{1'b0}}};

    logic                       adv;
    logic [NSTG-1:0]            vld_reg;
    logic [NSTG-1:0]            vld_next;

    logic [TQ_W-1:0]            tq_reg;
    logic [T2_W-1:0]            t2_reg;
    logic [T2_W-1:0]            t2_next;
    logic [T3_W-1:0]            t3_reg;
    logic [T3_W-1:0]            t3_next;
    logic signed [ACC_W-1:0]    p2_reg;
    logic signed [ACC_W-1:0]    p2_next;
    logic signed [ACC_W-1:0]    p2d_reg;
    logic signed [ACC_W-1:0]    p3_reg;
    logic signed [ACC_W-1:0]    p3_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic [NSTG-2:0]            neg_reg;
    logic [SINE_W-1:0]          sine_reg;
    logic [SINE_W-1:0]          sine_next;

    logic [TQ_W-1:0]            tq;
    logic [2*TQ_W-1:0]          sq;
    logic [T2_W+TQ_W-1:0]       cube;
    logic signed [VW-1:0]       v;
    logic signed [VW-1:0]       nv;
    logic signed [VW-1:0]       vc;
    logic [ACC_W-1:0]           vx;

    assign adv        = !vld_reg[NSTG-1] || out_ready;
    assign in_ready   = adv;
    assign out_valid  = vld_reg[NSTG-1];
    assign sine_value = sine_reg;

    always_comb
    begin
        vld_next = adv ? {vld_reg[NSTG-2:0], in_valid} : vld_reg;

        // square, then cube and the quadratic term
        tq      = in_item.t[T_W-1:2];
        sq      = tq * tq;
        t2_next = sq[2*TQ_W-1:30];
        cube    = t2_reg * tq_reg;
        t3_next = cube[T2_W+TQ_W-1:30];
        p2_next = A2_Q30 * $signed({1'b0, t2_reg});
        p3_next = A3_Q30 * $signed({1'b0, t3_reg});

        // sum in Q.60 with the half-unit bias for rounding
        acc_next = ONE_Q60 + p2d_reg + p3_reg + RND_BIAS;

        // drop fraction, apply sign, clamp to plus or minus one
        v  = $signed(acc_reg[SH+VW-1:SH]);
        nv = neg_reg[NSTG-2] ? -v : v;
        if (nv > V_ONE)
        begin
            vc = V_ONE;
        end
        else if (nv < -V_ONE)
        begin
            vc = -V_ONE;
        end
        else
        begin
            vc = nv;
        end
        vx        = {{(ACC_W - VW){vc[VW-1]}}, vc};
        sine_next = vx[SINE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tq_reg   <= tq;
            t2_reg   <= t2_next;
            t3_reg   <= t3_next;
            p2_reg   <= p2_next;
            p2d_reg  <= p2_reg;
            p3_reg   <= p3_next;
            acc_reg  <= acc_next;
            neg_reg  <= {neg_reg[NSTG-3:0], in_item.neg};
            sine_reg <= sine_next;
        end
    end

endmodule

>>> rtl/piecewise_cubic_sine_approx.sv
// Channel   Direction  Handshake                      Payload
// input     in         push / full, taken: push & !full   angle (s32, radians)
// result    out        empty / pop, taken: pop & !empty   sine_value (s16)
//
// One item per cycle sustained while results are popped as they arrive; a stalled result side holds the flow.
// The path runs through two five-stage pipelines (range reduction, polynomial),
// the queue between them and the result queue.
// Reset clears all valid bits and queue pointers; payload registers are left alone.
// A stalled result side fills the result queue, then the back pipeline, the middle
// queue and the front pipeline, after which full rises; no item is dropped.
module piecewise_cubic_sine_approx #(
    parameter int unsigned ANGLE_FRAC_BITS  = pcsa_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int unsigned RESULT_FRAC_BITS = pcsa_pkg::RESULT_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [pcsa_pkg::ANGLE_W-1:0] angle,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [pcsa_pkg::SINE_W-1:0]  sine_value
);

    import pcsa_pkg::*;

    // front side handshake
    logic              front_ready;
    logic              front_valid;
    pcsa_mid_t         front_item;

    // middle queue between reduction and polynomial
    logic              mid_full;
    logic              mid_empty;
    pcsa_mid_t         mid_item;
    logic              back_ready;

    // back side to the result queue
    logic              back_valid;
    logic              res_full;
    logic [SINE_W-1:0] back_sine;
    logic [SINE_W-1:0] res_data;

    // hold input whenever the front pipeline cannot advance
    assign full       = !front_ready;
    assign sine_value = $signed(res_data);

    // reduce the angle to [0, 2*pi), pick the quadrant and the offset t
    pcsa_front #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push),
        .in_ready  (front_ready),
        .angle     (angle),
        .out_valid (front_valid),
        .out_ready (!mid_full),
        .out_item  (front_item)
    );

    // decouple the two pipelines so each stalls on its own
    pcsa_fifo #(
        .WIDTH ($bits(pcsa_mid_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_valid),
        .wdata (front_item),
        .full  (mid_full),
        .pop   (back_ready),
        .rdata (mid_item),
        .empty (mid_empty)
    );

    // evaluate the cubic hill, round, apply sign and clamp
    pcsa_back #(
        .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (!mid_empty),
        .in_ready   (back_ready),
        .in_item    (mid_item),
        .out_valid  (back_valid),
        .out_ready  (!res_full),
        .sine_value (back_sine)
    );

    // result queue: the head item drives the result ports
    pcsa_fifo #(
        .WIDTH (SINE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_valid),
        .wdata (back_sine),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_data),
        .empty (empty)
    );

endmodule
